>>> hdl/dshp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and code tables of the depth span packer.
// Depends on nothing; every file of the block but dshp_ifs imports it.
package dshp_pkg;

    localparam int DEPTH_W = 11;
    localparam int WORD_W  = 32;
    localparam int CHUNK_W = 32;
    localparam int LEN_W   = 6;
    localparam int FILL_W  = 5;
    localparam int RUN_W   = 9;

    localparam logic [DEPTH_W-1:0] MARKER_RESET = 11'h7FF;
    localparam logic [RUN_W-1:0]   RUN_CAP      = 9'd256;
    localparam logic [13:0]        TERM_CODE    = 14'hB;
    localparam logic [3:0]         TERM_LEN     = 4'd5;
    localparam logic [3:0]         HEADER_LEN   = 4'd12;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'b001,
        MODE_VALID = 3'b010,
        MODE_RUN   = 3'b100
    } t_mode;

    // One pixel's worth of stream bits, right aligned, upper bits zero.
    typedef struct packed {
        logic [CHUNK_W-1:0] bits;
        logic [LEN_W-1:0]   len;
        logic               eof;
    } t_chunk;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_word;

    // Delta code by biased delta (delta + 16): length in [15:12], code in [11:0].
    function automatic logic [15:0] delta_code(input logic [4:0] k);
        logic [15:0] r;
        case (k)
            5'd0:  r = {4'd5,  12'hB};
            5'd1:  r = {4'd11, 12'h23B};
            5'd2:  r = {4'd11, 12'h229};
            5'd3:  r = {4'd11, 12'h222};
            5'd4:  r = {4'd11, 12'h226};
            5'd5:  r = {4'd11, 12'h239};
            5'd6:  r = {4'd11, 12'h224};
            5'd7:  r = {4'd12, 12'h47F};
            5'd8:  r = {4'd11, 12'h22B};
            5'd9:  r = {4'd11, 12'h23D};
            5'd10: r = {4'd11, 12'h23E};
            5'd11: r = {4'd10, 12'h116};
            5'd12: r = {4'd9,  12'h8C};
            5'd13: r = {4'd7,  12'h20};
            5'd14: r = {4'd5,  12'h9};
            5'd15: r = {4'd2,  12'h0};
            5'd16: r = {4'd1,  12'h1};
            5'd17: r = {4'd3,  12'h3};
            5'd18: r = {4'd5,  12'hA};
            5'd19: r = {4'd7,  12'h21};
            5'd20: r = {4'd9,  12'h8D};
            5'd21: r = {4'd10, 12'h117};
            5'd22: r = {4'd10, 12'h110};
            5'd23: r = {4'd11, 12'h23C};
            5'd24: r = {4'd11, 12'h22A};
            5'd25: r = {4'd12, 12'h47E};
            5'd26: r = {4'd11, 12'h225};
            5'd27: r = {4'd11, 12'h238};
            5'd28: r = {4'd11, 12'h228};
            5'd29: r = {4'd11, 12'h223};
            5'd30: r = {4'd11, 12'h227};
            default: r = {4'd11, 12'h23A};
        endcase
        return r;
    endfunction

    // Run length code by (run - 1): length in [17:14], code in [13:0].
    localparam logic [17:0] RUN_TAB [256] = '{
        {4'd3,14'h2},{4'd3,14'h0},{4'd5,14'hE},{4'd6,14'h1F},{4'd6,14'h18},
        {4'd6,14'h9},{4'd7,14'h1B},{4'd7,14'h3D},{4'd7,14'h33},{4'd6,14'hB},
        {4'd8,14'h3B},{4'd7,14'h36},{4'd8,14'h3D},{4'd8,14'h65},{4'd8,14'h6B},
        {4'd8,14'h3E},{4'd8,14'h33},{4'd9,14'hDF},{4'd9,14'h73},{4'd8,14'h22},
        {4'd8,14'h29},{4'd9,14'hDD},{4'd9,14'h60},{4'd10,14'h1A1},{4'd9,14'h69},
        {4'd9,14'h79},{4'd10,14'h1E3},{4'd10,14'hD0},{4'd10,14'hC8},{4'd10,14'hE9},
        {4'd10,14'hCA},{4'd10,14'h1A9},{4'd10,14'h1A7},{4'd9,14'h40},{4'd10,14'hAE},
        {4'd10,14'h1A6},{4'd10,14'h1A5},{4'd9,14'h62},{4'd10,14'h1A4},{4'd9,14'h50},
        {4'd9,14'h70},{4'd9,14'h7F},{4'd10,14'h1E5},{4'd10,14'hA3},{4'd11,14'h18F},
        {4'd11,14'h344},{4'd11,14'h357},{4'd10,14'hD7},{4'd10,14'hA8},{4'd10,14'h1B8},
        {4'd10,14'h84},{4'd9,14'h61},{4'd10,14'h83},{4'd11,14'h3C1},{4'd11,14'h152},
        {4'd12,14'h79F},{4'd11,14'h154},{4'd10,14'h85},{4'd11,14'h378},{4'd11,14'h3CD},
        {4'd11,14'h321},{4'd11,14'h355},{4'd11,14'h373},{4'd11,14'h3C2},{4'd11,14'h350},
        {4'd11,14'h1F9},{4'd11,14'h1C7},{4'd11,14'h347},{4'd11,14'h354},{4'd11,14'h1C6},
        {4'd12,14'h6AC},{4'd11,14'h105},{4'd11,14'h193},{4'd11,14'h1A8},{4'd12,14'h79E},
        {4'd12,14'h3AC},{4'd12,14'h645},{4'd12,14'h799},{4'd12,14'h3AD},{4'd11,14'h18D},
        {4'd12,14'h79D},{4'd11,14'h118},{4'd11,14'h157},{4'd11,14'h345},{4'd11,14'h3C4},
        {4'd11,14'h1D5},{4'd12,14'h3A8},{4'd12,14'h64B},{4'd11,14'h158},{4'd11,14'h1D1},
        {4'd12,14'h790},{4'd12,14'h3F7},{4'd12,14'h64A},{4'd12,14'h6A2},{4'd12,14'h356},
        {4'd12,14'h219},{4'd12,14'h23C},{4'd12,14'h318},{4'd13,14'hDC8},{4'd12,14'h389},
        {4'd12,14'h6F5},{4'd11,14'h11D},{4'd12,14'h64F},{4'd12,14'h6A3},{4'd11,14'h11C},
        {4'd11,14'h196},{4'd12,14'h78A},{4'd12,14'h357},{4'd12,14'h344},{4'd12,14'h646},
        {4'd12,14'h352},{4'd12,14'h23E},{4'd12,14'h2B2},{4'd12,14'h233},{4'd13,14'hC98},
        {4'd12,14'h2B3},{4'd12,14'h324},{4'd12,14'h345},{4'd13,14'h786},{4'd13,14'hDE5},
        {4'd12,14'h232},{4'd12,14'h35B},{4'd12,14'h218},{4'd12,14'h23D},{4'd13,14'hD5A},
        {4'd12,14'h2A7},{4'd12,14'h208},{4'd12,14'h3C6},{4'd13,14'hF22},{4'd12,14'h683},
        {4'd13,14'hF0C},{4'd12,14'h3F4},{4'd12,14'h346},{4'd12,14'h3C4},{4'd12,14'h2AB},
        {4'd12,14'h2BD},{4'd12,14'h647},{4'd12,14'h64D},{4'd12,14'h2B4},{4'd13,14'hC9C},
        {4'd13,14'h7EC},{4'd13,14'hF03},{4'd13,14'h7EB},{4'd13,14'hF38},{4'd13,14'hF17},
        {4'd12,14'h2AA},{4'd13,14'hDEE},{4'd12,14'h358},{4'd12,14'h38A},{4'd12,14'h3C5},
        {4'd12,14'h23F},{4'd12,14'h32E},{4'd12,14'h649},{4'd11,14'h18E},{4'd12,14'h3A9},
        {4'd12,14'h388},{4'd12,14'h2B7},{4'd12,14'h3F0},{4'd12,14'h2BC},{4'd12,14'h3C0},
        {4'd12,14'h2AD},{4'd12,14'h353},{4'd12,14'h2AC},{4'd12,14'h6E5},{4'd11,14'h10E},
        {4'd11,14'h1AA},{4'd12,14'h640},{4'd11,14'h144},{4'd11,14'h10F},{4'd11,14'h340},
        {4'd12,14'h6F4},{4'd12,14'h3C1},{4'd12,14'h641},{4'd12,14'h3F1},{4'd12,14'h3A0},
        {4'd13,14'hF0E},{4'd13,14'hD05},{4'd13,14'hD1A},{4'd13,14'hDE4},{4'd12,14'h2A6},
        {4'd12,14'h209},{4'd13,14'hF39},{4'd13,14'h632},{4'd13,14'h68F},{4'd13,14'hD18},
        {4'd13,14'hF24},{4'd13,14'hF25},{4'd13,14'hDEC},{4'd13,14'hDE6},{4'd13,14'hDEF},
        {4'd13,14'hDE7},{4'd9,14'h72},{4'd12,14'h28B},{4'd12,14'h3AE},{4'd13,14'hF00},
        {4'd13,14'h787},{4'd13,14'hD1B},{4'd13,14'hF31},{4'd13,14'hF26},{4'd13,14'hC99},
        {4'd12,14'h359},{4'd12,14'h2BE},{4'd12,14'h2B5},{4'd13,14'hF23},{4'd13,14'h56C},
        {4'd13,14'h75E},{4'd13,14'hF27},{4'd12,14'h32F},{4'd13,14'hF16},{4'd12,14'h3C7},
        {4'd13,14'h68E},{4'd11,14'h11A},{4'd13,14'hD5B},{4'd12,14'h21B},{4'd13,14'h785},
        {4'd13,14'hC89},{4'd12,14'h237},{4'd13,14'hF0F},{4'd13,14'h743},{4'd13,14'h64B},
        {4'd13,14'h46D},{4'd13,14'h435},{4'd14,14'h1BDA},{4'd14,14'h1E60},{4'd13,14'h46C},
        {4'd13,14'h57F},{4'd14,14'hF08},{4'd14,14'hF09},{4'd14,14'h1BDB},{4'd13,14'h514},
        {4'd14,14'h1E61},{4'd13,14'h633},{4'd13,14'h742},{4'd13,14'hD19},{4'd13,14'hDC9},
        {4'd13,14'h716},{4'd13,14'h64A},{4'd13,14'h7EA},{4'd13,14'h75F},{4'd13,14'hC90},
        {4'd13,14'h6B4},{4'd13,14'h6B5},{4'd13,14'hD04},{4'd13,14'hF01},{4'd13,14'hF02},
        {4'd13,14'h7ED},{4'd13,14'h515},{4'd13,14'h434},{4'd13,14'h56D},{4'd13,14'hC91},
        {4'd13,14'hC88},{4'd13,14'h717},{4'd13,14'h57E},{4'd13,14'hC9D},{4'd13,14'hF0D},
        {4'd1,14'h1}
    };

endpackage

>>> hdl/dshp_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixels in and stream words out.
// Depends on nothing.
interface dshp_pix_if;
    logic        valid;
    logic        ready;
    logic [10:0] depth;
    logic        end_of_frame;
    modport source (output valid, output depth, output end_of_frame, input ready);
    modport sink   (input valid, input depth, input end_of_frame, output ready);
endinterface

interface dshp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;
    logic        frame_end;
    modport source (output valid, output packed_word, output frame_end, input ready);
    modport sink   (input valid, input packed_word, input frame_end, output ready);
endinterface

>>> hdl/dshp_front.sv
`timescale 1ns / 1ps
// Front end: classifies each pixel against the span state and builds its bit chunk.
// Depends on dshp_pkg.
module dshp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [10:0]            i_cfg_wr_data,
    input  logic                   i_accept,
    input  logic [10:0]            i_depth,
    input  logic                   i_eof,
    output dshp_pkg::t_chunk       o_chunk
);
    import dshp_pkg::*;

    t_mode               r_mode, n_mode;
    logic [DEPTH_W-1:0]  r_prev, n_prev;
    logic [RUN_W-1:0]    r_run, n_run;
    logic [DEPTH_W-1:0]  r_marker;

    logic [13:0] a_bits, c_bits;
    logic [3:0]  a_len, c_len;
    logic [11:0] b_bits;
    logic [3:0]  b_len;
    logic        do_open;
    logic signed [DEPTH_W:0] diff;
    logic [15:0] dcode;
    logic [17:0] run_a, run_c;
    logic [25:0] ab;
    logic [CHUNK_W-1:0] abc;

    assign diff  = $signed({1'b0, i_depth}) - $signed({1'b0, r_prev});
    assign dcode = delta_code(diff[4:0] + 5'd16);
    assign run_a = RUN_TAB[8'(r_run - 9'd1)];
    assign run_c = RUN_TAB[8'(n_run - 9'd1)];

    always_comb begin
        a_bits = '0; a_len = '0;
        b_bits = '0; b_len = '0;
        c_bits = '0; c_len = '0;
        do_open = 1'b0;
        n_mode = r_mode;
        n_prev = r_prev;
        n_run  = r_run;
        case (r_mode)
            MODE_VALID: begin
                if (diff >= -12'sd15 && diff <= 12'sd15) begin
                    b_bits = dcode[11:0];
                    b_len  = dcode[15:12];
                    n_prev = i_depth;
                end else begin
                    a_bits  = TERM_CODE;
                    a_len   = TERM_LEN;
                    do_open = 1'b1;
                end
            end
            MODE_RUN: begin
                if (i_depth == r_marker && r_run < RUN_CAP) begin
                    n_run = r_run + 9'd1;
                end else begin
                    // The run code carries one extra leading zero bit.
                    a_bits  = run_a[13:0];
                    a_len   = run_a[17:14] + 4'd1;
                    do_open = 1'b1;
                end
            end
            default: begin
                do_open = 1'b1;
            end
        endcase
        if (do_open) begin
            if (i_depth != r_marker) begin
                b_bits = {1'b1, i_depth};
                b_len  = HEADER_LEN;
                n_prev = i_depth;
                n_mode = MODE_VALID;
            end else begin
                n_run  = 9'd1;
                n_mode = MODE_RUN;
            end
        end
        if (i_eof) begin
            if (n_mode == MODE_VALID) begin
                c_bits = TERM_CODE;
                c_len  = TERM_LEN;
            end else if (n_mode == MODE_RUN) begin
                c_bits = run_c[13:0];
                c_len  = run_c[17:14] + 4'd1;
            end
            n_mode = MODE_NONE;
        end
    end

    assign ab  = ({12'd0, a_bits} << b_len) | {14'd0, b_bits};
    assign abc = ({6'd0, ab} << c_len) | {18'd0, c_bits};

    always_comb begin
        o_chunk.bits = abc;
        o_chunk.len  = LEN_W'({2'b0, a_len} + {2'b0, b_len} + {2'b0, c_len});
        o_chunk.eof  = i_eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NONE;
            r_prev   <= '0;
            r_run    <= '0;
            r_marker <= MARKER_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_marker <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_mode <= n_mode;
                r_prev <= n_prev;
                r_run  <= n_run;
            end
        end
    end

endmodule

>>> hdl/dshp_queue.sv
`timescale 1ns / 1ps
// Two-entry chunk queue between the front end and the packer.
// Depends on dshp_pkg.
module dshp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dshp_pkg::t_chunk i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output dshp_pkg::t_chunk o_data
);
    import dshp_pkg::*;

    t_chunk     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> hdl/dshp_back.sv
`timescale 1ns / 1ps
// Back end: packs chunks MSB first into 32-bit words and queues them for output.
// Depends on dshp_pkg and dshp_word_if.
module dshp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  dshp_pkg::t_chunk   i_chunk,
    output logic               o_pop,
    dshp_word_if.source        o_word
);
    import dshp_pkg::*;

    logic [CHUNK_W-1:0] r_buf, n_buf;
    logic [FILL_W-1:0]  r_fill, n_fill;
    t_word              r_oq [4];
    logic [1:0]         r_wp, r_rp;
    logic [2:0]         r_cnt;

    logic [63:0] acc, mask;
    logic [5:0]  total;
    logic        full;
    logic [4:0]  rem;
    logic [31:0] pad;
    logic        push0, push1;
    t_word       w0, w1;
    logic        out_pop;

    assign o_pop = !i_empty && (r_cnt <= 3'd2);

    assign acc   = ({32'd0, r_buf} << i_chunk.len) | {32'd0, i_chunk.bits};
    assign total = {1'b0, r_fill} + i_chunk.len;
    assign full  = total[5];
    assign rem   = total[4:0];
    assign mask  = (64'd1 << rem) - 64'd1;
    assign pad   = CHUNK_W'(acc & mask) << (6'd32 - {1'b0, rem});

    always_comb begin
        w0.word = 32'(acc >> rem);
        w0.last = i_chunk.eof && (rem == 5'd0);
        w1.word = pad;
        w1.last = 1'b1;
        push0 = o_pop && full;
        push1 = o_pop && i_chunk.eof && (rem != 5'd0);
        n_buf  = CHUNK_W'(acc & mask);
        n_fill = rem;
        if (i_chunk.eof) begin
            n_buf  = '0;
            n_fill = '0;
        end
    end

    assign out_pop            = o_word.valid && o_word.ready;
    assign o_word.valid       = (r_cnt != 3'd0);
    assign o_word.packed_word = r_oq[r_rp].word;
    assign o_word.frame_end   = r_oq[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_oq[r_wp] <= w0;
        end
        if (push1) begin
            r_oq[push0 ? r_wp + 2'd1 : r_wp] <= w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_fill <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            if (o_pop) begin
                r_buf  <= n_buf;
                r_fill <= n_fill;
            end
            r_wp  <= r_wp + {1'b0, push0} + {1'b0, push1};
            if (out_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, push0} + {2'd0, push1} - {2'd0, out_pop};
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("output queue overflow");
    a_eof_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_chunk.eof) |=> (r_fill == 5'd0))
        else $error("bit buffer not flushed at frame end");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push0 || push1) |-> (r_cnt <= 3'd2))
        else $error("word pushed without room");

endmodule

>>> hdl/depth_span_huffman_packer.sv
`timescale 1ns / 1ps
// Top level of the depth span packer: front end, chunk queue and word packer.
// Depends on dshp_pkg, dshp_ifs, dshp_front, dshp_queue and dshp_back.
//
// Usage: depth pixels enter on i_pix (valid/ready) in traversal order, each
// with an end_of_frame flag. Compressed stream words leave on o_word, MSB
// first, with frame_end set on the final word of each frame, zero-padded as needed.
// The invalid marker is written through i_cfg_wr_en / i_cfg_wr_data while
// the block is idle; it resets to 2047.
//
// Throughput is one pixel per cycle while the chunk queue has room: the front
// end codes a pixel in the cycle it is accepted, so the span state loop is
// closed by combinational logic. Each pixel yields at most 32 bits, hence at
// most one full word, plus the padded word at frame end. A pixel's bits are
// registered in the chunk queue, then in the bit buffer or output word queue.
//
// Synchronous active-low reset empties both queues and the bit buffer and
// closes any open span. When the receiver stalls, words collect in a
// four-word output queue; once it holds more than two, the packer stops
// taking chunks, the two-entry chunk queue fills and i_pix.ready drops.
module depth_span_huffman_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    dshp_pix_if.sink    i_pix,
    dshp_word_if.source o_word
);
    import dshp_pkg::*;

    t_chunk front_chunk;
    t_chunk queue_chunk;
    logic   q_full, q_empty, q_pop;
    logic   accept;

    // The pixel is taken whenever the chunk queue has room.
    assign i_pix.ready = !q_full;
    assign accept      = i_pix.valid && !q_full;

    dshp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_depth      (i_pix.depth),
        .i_eof        (i_pix.end_of_frame),
        .o_chunk      (front_chunk)
    );

    dshp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (front_chunk),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (queue_chunk)
    );

    dshp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_chunk(queue_chunk),
        .o_pop  (q_pop),
        .o_word (o_word)
    );

endmodule
